>>> design/cst_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cst_pkg
// Shared types, codes and defaults for the counting semaphore table.
// ----------------------------------------------------------------------------
package cst_pkg;

  localparam int SemCountDef  = 16;
  localparam int WaitDepthDef = 16;
  localparam int ProcCountDef = 16;

  localparam int CountW = 16;
  localparam int IdW    = 4;
  localparam int PidW   = 4;
  localparam logic [CountW-1:0] CountMax = '1;

  typedef enum logic [1:0] {
    OpAlloc = 2'd0,
    OpFree  = 2'd1,
    OpWait  = 2'd2,
    OpPost  = 2'd3
  } op_e;

  // Controller to datapath.
  typedef struct packed {
    logic load;     // capture the request
    logic execute;  // decide and update state
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic done;     // result register filled
  } stat_t;

endpackage

>>> design/counting_semaphore_table_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// counting_semaphore_table_core
// Semaphore table with free-id FIFO and per-semaphore FIFO wait queues.
// ----------------------------------------------------------------------------
// Channel | Dir | tdata (low to high)                         | tuser
// s_axis  | in  | op, sem_id, init_value, caller_pid (26->32) | -
// m_axis  | out | status, result_value, caller_blocked,       | -
//         |     | wake_valid, wake_pid (23->24)               |
// One request at a time: accept (and prefetch the queue head), update the
// tables and register the result, let the registered done flag reach the
// sequencer, then hold the result until taken; the load, execute and done
// steps run in order, and no new request is taken before the result is.
// Reset frees all ids and empties all queues at once; no clearing pass.
// A stalled result holds the input side not ready.
module counting_semaphore_table_core #(
  parameter int SemCount  = cst_pkg::SemCountDef,
  parameter int WaitDepth = cst_pkg::WaitDepthDef,
  parameter int ProcCount = cst_pkg::ProcCountDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  output logic        s_tready_o,
  input  logic [31:0] s_tdata_i,   // op[1:0], sem_id[5:2], init_value[21:6], caller_pid[25:22]
  output logic        m_tvalid_o,
  input  logic        m_tready_i,
  output logic [23:0] m_tdata_o    // status[0], result_value[16:1], caller_blocked[17],
                                   // wake_valid[18], wake_pid[22:19]
);

  cst_pkg::cmd_t  cmd;
  cst_pkg::stat_t stat;
  logic                       status, blocked, wake_valid;
  logic [cst_pkg::CountW-1:0] result_value;
  logic [cst_pkg::PidW-1:0]   wake_pid;

  cst_ctrl u_ctrl (
    .clk_i, .rst_ni, .s_tvalid_i, .s_tready_o, .m_tvalid_o, .m_tready_i,
    .cmd_o(cmd), .stat_i(stat)
  );

  cst_dp #(
    .SemCount(SemCount), .WaitDepth(WaitDepth), .ProcCount(ProcCount)
  ) u_dp (
    .clk_i, .rst_ni,
    .cmd_i(cmd), .stat_o(stat),
    .op_i(s_tdata_i[1:0]), .sem_id_i(s_tdata_i[5:2]),
    .init_value_i(s_tdata_i[21:6]), .caller_pid_i(s_tdata_i[25:22]),
    .status_o(status), .result_value_o(result_value),
    .caller_blocked_o(blocked), .wake_valid_o(wake_valid), .wake_pid_o(wake_pid)
  );

  assign m_tdata_o = {1'b0, wake_pid, wake_valid, blocked, result_value, status};

endmodule

>>> design/cst_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cst_ctrl
// Sequencer: load a request, execute it, hold the result until taken.
// ----------------------------------------------------------------------------
module cst_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           s_tvalid_i,
  output logic           s_tready_o,
  output logic           m_tvalid_o,
  input  logic           m_tready_i,
  output cst_pkg::cmd_t  cmd_o,
  input  cst_pkg::stat_t stat_i
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StExec = 2'd1;
  localparam logic [1:0] StOut  = 2'd2;

  logic [1:0] state_q, state_d;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: if (s_tvalid_i) state_d = StExec;
      StExec: if (stat_i.done) state_d = StOut;
      StOut:  if (m_tready_i) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= StIdle;
    else         state_q <= state_d;
  end

  // Execute exactly once: drop the command once the datapath reports done
  assign s_tready_o    = (state_q == StIdle);
  assign m_tvalid_o    = (state_q == StOut);
  assign cmd_o.load    = (state_q == StIdle) && s_tvalid_i;
  assign cmd_o.execute = (state_q == StExec) && !stat_i.done;

endmodule

>>> design/cst_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cst_dp
// Semaphore tables, free-id FIFO and wait queue memory with result register.
// ----------------------------------------------------------------------------
module cst_dp #(
  parameter int SemCount  = cst_pkg::SemCountDef,
  parameter int WaitDepth = cst_pkg::WaitDepthDef,
  parameter int ProcCount = cst_pkg::ProcCountDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  cst_pkg::cmd_t             cmd_i,
  output cst_pkg::stat_t            stat_o,
  input  logic [1:0]                op_i,
  input  logic [cst_pkg::IdW-1:0]   sem_id_i,
  input  logic [cst_pkg::CountW-1:0] init_value_i,
  input  logic [cst_pkg::PidW-1:0]  caller_pid_i,
  output logic                      status_o,
  output logic [cst_pkg::CountW-1:0] result_value_o,
  output logic                      caller_blocked_o,
  output logic                      wake_valid_o,
  output logic [cst_pkg::PidW-1:0]  wake_pid_o
);

  localparam int SW = (SemCount > 1) ? $clog2(SemCount) : 1;
  localparam int QW = (WaitDepth > 1) ? $clog2(WaitDepth) : 1;
  localparam int FW = $clog2(SemCount + 1);
  localparam int WFW = $clog2(WaitDepth + 1);
  localparam int CW = cst_pkg::CountW;
  localparam int PW = cst_pkg::PidW;

  // Captured request
  logic [1:0]    op_q;
  logic [cst_pkg::IdW-1:0] id_q;
  logic [CW-1:0] init_q;
  logic [PW-1:0] pid_q;

  // State tables
  logic [CW-1:0]  cnt_q   [SemCount];
  logic           used_q  [SemCount];
  logic [QW-1:0]  whead_q [SemCount];
  logic [WFW-1:0] wfill_q [SemCount];
  logic [SW-1:0]  fids_q  [SemCount];
  logic [SW-1:0]  fhead_q;
  logic [FW-1:0]  ffill_q;
  logic [PW-1:0]  wmem    [1 << (SW + QW)];
  logic [PW-1:0]  wrd_q;

  logic           done_q;

  // Decode of the captured request
  logic           id_ok;
  logic [SW-1:0]  sid;
  logic [CW-1:0]  cnt;
  logic [QW-1:0]  wh;
  logic [WFW-1:0] wf;
  logic [SW-1:0]  got;
  logic [31:0]    fsum;
  logic [31:0]    wsum;
  logic [SW-1:0]  ftail;
  logic [QW-1:0]  wslot;
  logic [SW-1:0]  fhead_nx;
  logic [QW-1:0]  whead_nx;
  logic [CW-1:0]  cnt_inc;

  assign id_ok  = ({{(32-cst_pkg::IdW){1'b0}}, id_q} < SemCount);
  assign sid    = SW'(id_q);
  assign cnt    = cnt_q[sid];
  assign wh     = whead_q[sid];
  assign wf     = wfill_q[sid];
  assign got    = fids_q[fhead_q];

  // Wrap ring positions by compare and subtract
  assign fsum     = 32'(fhead_q) + 32'(ffill_q);
  assign wsum     = 32'(wh) + 32'(wf);
  assign ftail    = SW'((fsum >= SemCount) ? fsum - SemCount : fsum);
  assign wslot    = QW'((wsum >= WaitDepth) ? wsum - WaitDepth : wsum);
  assign fhead_nx = (32'(fhead_q) == SemCount - 1) ? '0 : fhead_q + 1'b1;
  assign whead_nx = (32'(wh) == WaitDepth - 1) ? '0 : wh + 1'b1;
  assign cnt_inc  = (cnt == cst_pkg::CountMax) ? cnt : cnt + 1'b1;

  // Capture request and prefetch queue head on load
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q   <= op_i;
      id_q   <= sem_id_i;
      init_q <= init_value_i;
      pid_q  <= caller_pid_i;
      wrd_q  <= wmem[{SW'(sem_id_i), whead_q[SW'(sem_id_i)]}];
    end
  end

  // Wait queue memory write
  always_ff @(posedge clk_i) begin
    if (cmd_i.execute && op_q == cst_pkg::OpWait && id_ok && used_q[sid]
        && cnt == '0 && 32'(wf) < WaitDepth && 32'(pid_q) < ProcCount) begin
      wmem[{sid, wslot}] <= pid_q;
    end
  end

  // Execute one operation
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SemCount; i++) begin
        cnt_q[i]   <= '0;
        used_q[i]  <= 1'b0;
        whead_q[i] <= '0;
        wfill_q[i] <= '0;
        fids_q[i]  <= SW'(i);
      end
      fhead_q          <= '0;
      ffill_q          <= FW'(SemCount);
      done_q           <= 1'b0;
      status_o         <= 1'b0;
      result_value_o   <= '0;
      caller_blocked_o <= 1'b0;
      wake_valid_o     <= 1'b0;
      wake_pid_o       <= '0;
    end else begin
      done_q <= cmd_i.execute;
      if (cmd_i.execute) begin
        status_o         <= 1'b1;
        result_value_o   <= '0;
        caller_blocked_o <= 1'b0;
        wake_valid_o     <= 1'b0;
        wake_pid_o       <= '0;
        if (op_q == cst_pkg::OpAlloc) begin
          if (ffill_q != '0) begin
            fhead_q        <= fhead_nx;
            ffill_q        <= ffill_q - 1'b1;
            cnt_q[got]     <= init_q;
            used_q[got]    <= 1'b1;
            whead_q[got]   <= '0;
            wfill_q[got]   <= '0;
            status_o       <= 1'b0;
            result_value_o <= CW'(got);
          end
        end else if (id_ok && used_q[sid]) begin
          unique case (op_q)
            cst_pkg::OpFree: begin
              if (cnt == '0 && 32'(ffill_q) < SemCount) begin
                fids_q[ftail] <= sid;
                ffill_q       <= ffill_q + 1'b1;
                used_q[sid]   <= 1'b0;
                cnt_q[sid]    <= '0;
                whead_q[sid]  <= '0;
                wfill_q[sid]  <= '0;
                status_o      <= 1'b0;
              end
            end
            cst_pkg::OpWait: begin
              if (cnt != '0) begin
                cnt_q[sid]     <= cnt - 1'b1;
                status_o       <= 1'b0;
                result_value_o <= cnt - 1'b1;
              end else if (32'(wf) < WaitDepth && 32'(pid_q) < ProcCount) begin
                wfill_q[sid]     <= wf + 1'b1;
                status_o         <= 1'b0;
                caller_blocked_o <= 1'b1;
              end
            end
            cst_pkg::OpPost: begin
              status_o <= 1'b0;
              if (wf != '0) begin
                whead_q[sid]   <= whead_nx;
                wfill_q[sid]   <= wf - 1'b1;
                cnt_q[sid]     <= (cnt_inc != '0) ? cnt_inc - 1'b1 : cnt_inc;
                result_value_o <= (cnt_inc != '0) ? cnt_inc - 1'b1 : cnt_inc;
                wake_valid_o   <= 1'b1;
                wake_pid_o     <= wrd_q;
              end else begin
                cnt_q[sid]     <= cnt_inc;
                result_value_o <= cnt_inc;
              end
            end
            default: ;
          endcase
        end
      end
    end
  end

  assign stat_o.done = done_q;

endmodule

>>> tb/cst_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cst_checker
// Watches both streams of the semaphore table and keeps its own copy of the
// table state. Each request transaction yields one predicted result; each
// result transaction is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module cst_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  input  logic [31:0] s_tdata_i,   // op, sem_id, init_value, caller_pid
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  input  logic [23:0] m_tdata_i,   // status, result_value, caller_blocked,
                                   // wake_valid, wake_pid
  output int          fail_cnt_o,
  output int          pending_o
);

  localparam int NumSem  = cst_pkg::SemCountDef;
  localparam int QDepth  = cst_pkg::WaitDepthDef;
  localparam int NumProc = cst_pkg::ProcCountDef;

  typedef struct packed {
    logic                       status;
    logic [cst_pkg::CountW-1:0] value;
    logic                       blocked;
    logic                       wake_valid;
    logic [cst_pkg::PidW-1:0]   wake_pid;
  } sem_result_t;

  // Shadow copy of the table
  logic [cst_pkg::CountW-1:0] count_q   [NumSem];
  logic                       in_use_q  [NumSem];
  logic [cst_pkg::PidW-1:0]   waiters_q [NumSem][QDepth];
  int                         q_head    [NumSem];
  int                         q_fill    [NumSem];
  logic [cst_pkg::IdW-1:0]    free_ids  [NumSem];
  int                         free_head;
  int                         free_fill;

  sem_result_t expected_results[$];

  assign pending_o = expected_results.size();

  // Clear the shadow table to its reset contents
  task automatic clear_table();
    for (int i = 0; i < NumSem; i++) begin
      count_q[i]  = '0;
      in_use_q[i] = 1'b0;
      q_head[i]   = 0;
      q_fill[i]   = 0;
      free_ids[i] = cst_pkg::IdW'(i);
      for (int j = 0; j < QDepth; j++) waiters_q[i][j] = '0;
    end
    free_head = 0;
    free_fill = NumSem;
  endtask

  // Apply one request to the shadow table and return its result
  task automatic run_request(input cst_pkg::op_e op, input int id,
                             input logic [cst_pkg::CountW-1:0] init,
                             input int pid, output sem_result_t r);
    int got;
    r = '0;
    if (op == cst_pkg::OpAlloc) begin
      if (free_fill == 0) begin
        r.status = 1'b1;
        return;
      end
      got = free_ids[free_head];
      free_head = (free_head + 1) % NumSem;
      free_fill--;
      count_q[got]  = init;
      in_use_q[got] = 1'b1;
      q_head[got]   = 0;
      q_fill[got]   = 0;
      r.value = cst_pkg::CountW'(got);
      return;
    end
    if (id >= NumSem || !in_use_q[id]) begin
      r.status = 1'b1;
      return;
    end
    case (op)
      cst_pkg::OpFree: begin
        if (count_q[id] != 0 || free_fill >= NumSem) begin
          r.status = 1'b1;
          return;
        end
        free_ids[(free_head + free_fill) % NumSem] = cst_pkg::IdW'(id);
        free_fill++;
        in_use_q[id] = 1'b0;
        count_q[id]  = '0;
        q_head[id]   = 0;
        q_fill[id]   = 0;
      end
      cst_pkg::OpWait: begin
        if (count_q[id] != 0) begin
          count_q[id]--;
          r.value = count_q[id];
        end else if (q_fill[id] >= QDepth || pid >= NumProc) begin
          r.status = 1'b1;
        end else begin
          waiters_q[id][(q_head[id] + q_fill[id]) % QDepth] = cst_pkg::PidW'(pid);
          q_fill[id]++;
          r.value   = count_q[id];
          r.blocked = 1'b1;
        end
      end
      default: begin
        // Post: saturate, then hand the unit straight to the oldest waiter
        if (count_q[id] != cst_pkg::CountMax) count_q[id]++;
        if (q_fill[id] > 0) begin
          r.wake_valid = 1'b1;
          r.wake_pid   = waiters_q[id][q_head[id]];
          q_head[id]   = (q_head[id] + 1) % QDepth;
          q_fill[id]--;
          if (count_q[id] != 0) count_q[id]--;
        end
        r.value = count_q[id];
      end
    endcase
  endtask

  // Compare results first, then predict the newly accepted request
  always @(posedge clk_i or negedge rst_ni) begin
    sem_result_t exp_r;
    sem_result_t act_r;
    if (!rst_ni) begin
      clear_table();
      expected_results.delete();
      fail_cnt_o = 0;
    end else begin
      if (m_tvalid_i && m_tready_i) begin
        act_r = '{status: m_tdata_i[0], value: m_tdata_i[16:1], blocked: m_tdata_i[17],
                  wake_valid: m_tdata_i[18], wake_pid: m_tdata_i[22:19]};
        if (expected_results.size() == 0) begin
          $display("%0t: result with nothing expected: %h", $time, act_r);
          fail_cnt_o++;
        end else begin
          exp_r = expected_results.pop_front();
          if (act_r.status !== exp_r.status) begin
            $display("%0t: status expected %0d actual %0d", $time, exp_r.status,
                     act_r.status);
            fail_cnt_o++;
          end
          if (act_r.value !== exp_r.value) begin
            $display("%0t: result_value expected %0d actual %0d", $time, exp_r.value,
                     act_r.value);
            fail_cnt_o++;
          end
          if (act_r.blocked !== exp_r.blocked) begin
            $display("%0t: caller_blocked expected %0d actual %0d", $time, exp_r.blocked,
                     act_r.blocked);
            fail_cnt_o++;
          end
          if (act_r.wake_valid !== exp_r.wake_valid) begin
            $display("%0t: wake_valid expected %0d actual %0d", $time, exp_r.wake_valid,
                     act_r.wake_valid);
            fail_cnt_o++;
          end
          if (act_r.wake_pid !== exp_r.wake_pid) begin
            $display("%0t: wake_pid expected %0d actual %0d", $time, exp_r.wake_pid,
                     act_r.wake_pid);
            fail_cnt_o++;
          end
        end
      end
      if (s_tvalid_i && s_tready_i) begin
        run_request(cst_pkg::op_e'(s_tdata_i[1:0]), int'(s_tdata_i[5:2]), s_tdata_i[21:6],
                    int'(s_tdata_i[25:22]), exp_r);
        expected_results.push_back(exp_r);
      end
    end
  end

endmodule

>>> tb/tb_counting_semaphore_table_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_counting_semaphore_table_core
// Drives directed and random request sequences into the semaphore table:
// allocation runs up to exhaustion, wait queues filled past their depth,
// posts that wake waiters or saturate, and frees that succeed or are refused.
// Both sides idle at random; the checker compares every result transaction.
// ----------------------------------------------------------------------------
module tb_counting_semaphore_table_core;

  localparam int NumItems  = 850;
  localparam int HoldCycles = 200;
  localparam int StallLimit = 3000;

  logic        clk_i      = 1'b0;
  logic        rst_ni     = 1'b0;
  logic        s_tvalid   = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata    = '0;
  logic        m_tvalid;
  logic        m_tready   = 1'b0;
  logic [23:0] m_tdata;
  int          fail_cnt;
  int          pending;

  int sent_cnt    = 0;
  int tx_idle_pct = 22;
  int rx_idle_pct = 78;
  bit hold_req    = 1'b0;
  int hold_left   = 0;
  int quiet_cycles = 0;

  always #5 clk_i = ~clk_i;

  counting_semaphore_table_core i_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_tvalid_i(s_tvalid),
    .s_tready_o(s_tready),
    .s_tdata_i (s_tdata),
    .m_tvalid_o(m_tvalid),
    .m_tready_i(m_tready),
    .m_tdata_o (m_tdata)
  );

  cst_checker i_checker (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_tvalid_i(s_tvalid),
    .s_tready_i(s_tready),
    .s_tdata_i (s_tdata),
    .m_tvalid_i(m_tvalid),
    .m_tready_i(m_tready),
    .m_tdata_i (m_tdata),
    .fail_cnt_o(fail_cnt),
    .pending_o (pending)
  );

  // Drive the result side: random stalls, plus one long hold-off on request
  always @(posedge clk_i) begin
    if (hold_req && hold_left == 0) hold_left = HoldCycles;
    if (hold_left > 0) begin
      hold_left--;
      if (hold_left == 0) hold_req = 1'b0;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Abort when no transaction moves for too long
  always @(posedge clk_i) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= StallLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Offer one request and hold it until taken
  task automatic send_request(input cst_pkg::op_e op, input int id, input int init,
                              input int pid);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {6'b0, 4'(pid), 16'(init), 4'(id), 2'(op)};
    do @(posedge clk_i); while (!s_tready);
    sent_cnt++;
    // Switch idle mix and trigger the hold-off as the run advances
    if (sent_cnt == NumItems / 3) begin
      tx_idle_pct = 78;
      rx_idle_pct = 22;
    end else if (sent_cnt == 2 * NumItems / 3) begin
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      hold_req    = 1'b1;
    end
  endtask

  function automatic int rand_init();
    case ($urandom_range(9))
      0:       return 65535;
      1:       return $urandom_range(65535);
      default: return $urandom_range(3);
    endcase
  endfunction

  initial begin
    int id;
    int n;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: extremes, a refused free and requests to unallocated ids
    send_request(cst_pkg::OpAlloc, 0, 0, 0);          // id 0, count 0
    send_request(cst_pkg::OpAlloc, 7, 65535, 0);      // id 1, count max
    send_request(cst_pkg::OpPost, 1, 0, 0);           // saturates
    send_request(cst_pkg::OpWait, 0, 0, 15);          // blocks pid 15
    send_request(cst_pkg::OpWait, 0, 0, 0);           // blocks pid 0
    send_request(cst_pkg::OpPost, 0, 0, 0);           // wakes pid 15
    send_request(cst_pkg::OpFree, 1, 0, 0);           // refused, count positive
    send_request(cst_pkg::OpFree, 5, 0, 0);           // not allocated
    send_request(cst_pkg::OpWait, 9, 0, 3);           // not allocated
    send_request(cst_pkg::OpPost, 15, 0, 0);          // not allocated
    send_request(cst_pkg::OpWait, 1, 0, 0);           // plain decrement
    send_request(cst_pkg::OpPost, 0, 0, 0);           // wakes pid 0
    send_request(cst_pkg::OpPost, 0, 0, 0);           // no waiter, count up
    send_request(cst_pkg::OpWait, 0, 0, 0);           // back to zero
    send_request(cst_pkg::OpFree, 0, 0, 0);           // ok

    // Random sequences
    while (sent_cnt < NumItems) begin
      case ($urandom_range(9))
        0, 1: begin
          // Allocation burst, may run the free list dry
          n = $urandom_range(1, 17);
          repeat (n) send_request(cst_pkg::OpAlloc, $urandom_range(15), rand_init(),
                                  $urandom_range(15));
        end
        2, 3: begin
          // Drain a semaphore, queue waiters past the depth, then post
          id = $urandom_range(15);
          n = $urandom_range(1, 20);
          repeat (n) send_request(cst_pkg::OpWait, id, 0, $urandom_range(15));
          n = $urandom_range(1, 20);
          repeat (n) send_request(cst_pkg::OpPost, id, 0, 0);
        end
        4: begin
          // Release burst
          n = $urandom_range(1, 8);
          repeat (n) send_request(cst_pkg::OpFree, $urandom_range(15), 0, 0);
        end
        default: begin
          send_request(cst_pkg::op_e'($urandom_range(3)), $urandom_range(15), rand_init(),
                       $urandom_range(15));
        end
      endcase
    end
    s_tvalid <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
